/* src/rot_pkg.sv */
// Shared constants, types and codes for the record offset table.
package rot_pkg;

  localparam int RECORDS      = 4096;
  localparam int MAX_SEGMENTS = 8;

  localparam int RecNumW = 13;
  localparam int OffW    = 32;
  localparam int HighW   = 4;
  localparam int RecIdxW = $clog2(RECORDS);
  localparam int SegIdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SegCntW = $clog2(MAX_SEGMENTS + 1);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic               en;
    logic [RecIdxW-1:0] addr;
    logic [OffW-1:0]    data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [RecIdxW-1:0] addr_prev;
    logic [RecIdxW-1:0] addr_cur;
  } mem_rd_t;

  typedef struct packed {
    logic               en;
    logic [RecNumW-1:0] rec;
  } seg_log_t;

endpackage

/* src/rot_item_if.sv */
// Input channel carrying append and lookup transactions.
interface rot_item_if;
  import rot_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [RecNumW-1:0] rec_num;
  logic [OffW-1:0]    enc_len;

  modport source (output valid, output cmd, output rec_num, output enc_len, input ready);
  modport sink   (input valid, input cmd, input rec_num, input enc_len, output ready);
endinterface

/* src/rot_result_if.sv */
// Output channel carrying one result transaction per input item.
interface rot_result_if;
  import rot_pkg::*;

  logic             valid;
  logic             ready;
  logic [OffW-1:0]  offset_low;
  logic [HighW-1:0] offset_high;
  logic [OffW-1:0]  rec_length;
  logic             status;

  modport source (output valid, output offset_low, output offset_high, output rec_length,
                  output status, input ready);
  modport sink   (input valid, input offset_low, input offset_high, input rec_length,
                  input status, output ready);
endinterface

/* src/record_offset_table_top.sv */
// Top level of the record offset table: control, base register and result register.
// Each transaction is handled in the cycle it is accepted, in which both
// end-offset reads (previous and current record) are issued to the memory, and
// then in an execute cycle, in which the registered read data is used to form
// the result and, for an append to a record in range, the new end offset is
// written back and any 4 GB crossing is logged while the crossing table has
// room. The end-offset memory has registered read ports. A finished result
// waits in an output register, so a new transaction can be accepted while it
// is held; a result that is still held when the next one is ready keeps that
// item in its execute cycle. No clearing pass is needed after reset. Reading
// an end offset that was never written gives an undefined value.
module record_offset_table_top
  import rot_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [OffW-1:0]     cfg_wr_data,
  rot_item_if.sink            item,
  rot_result_if.source        result
);

  state_t             state, state_next;
  logic [OffW-1:0]    base_offset;
  logic               cmd;
  logic [RecNumW-1:0] rec_num;
  logic [OffW-1:0]    enc_len;

  logic               res_valid;
  logic [OffW-1:0]    res_low;
  logic [HighW-1:0]   res_high;
  logic [OffW-1:0]    res_len;
  logic               res_status;

  logic               accept;
  logic               exec_fire;
  logic               app_ok;
  logic               look_ok;
  logic               rec_zero;
  logic [OffW-1:0]    prev;
  logic [OffW:0]      sum;
  logic               carry;
  logic [OffW-1:0]    rd_prev;
  logic [OffW-1:0]    rd_cur;
  logic               seg_full;
  logic [HighW-1:0]   seg_count;
  logic [OffW-1:0]    low_next;
  logic [HighW-1:0]   high_next;
  logic [OffW-1:0]    len_next;
  logic               status_next;

  mem_wr_t            mem_wr;
  mem_rd_t            mem_rd;
  seg_log_t           seg_log;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign exec_fire  = (state == ST_EXEC) && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
    end else if (cfg_wr_en) begin
      base_offset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= item.cmd;
      rec_num <= item.rec_num;
      enc_len <= item.enc_len;
    end
  end

  // Record zero wraps the previous-entry address; its read data is not used.
  assign mem_rd.en        = accept;
  assign mem_rd.addr_prev = RecIdxW'(item.rec_num - RecNumW'(1));
  assign mem_rd.addr_cur  = RecIdxW'(item.rec_num);

  rot_end_mem u_end_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_prev (rd_prev),
    .rd_cur  (rd_cur)
  );

  assign rec_zero = (rec_num == '0);
  assign app_ok   = (32'(rec_num) < 32'(RECORDS));
  assign look_ok  = (32'(rec_num) <= 32'(RECORDS));
  assign prev     = rec_zero ? base_offset : rd_prev;
  assign sum      = {1'b0, prev} + {1'b0, enc_len};
  // A carry out needs a non-zero length, so a zero length never crosses.
  assign carry    = sum[OffW];

  assign mem_wr.en   = exec_fire && (cmd == CMD_APPEND) && app_ok;
  assign mem_wr.addr = RecIdxW'(rec_num);
  assign mem_wr.data = sum[OffW-1:0];

  assign seg_log.en  = exec_fire && (cmd == CMD_APPEND) && app_ok && carry;
  assign seg_log.rec = rec_num + RecNumW'(1);

  rot_seg_table u_seg_table (
    .clk     (clk),
    .rst     (rst),
    .log_req (seg_log),
    .query   (rec_num),
    .full    (seg_full),
    .count   (seg_count)
  );

  always_comb begin
    low_next    = '0;
    high_next   = '0;
    len_next    = '0;
    status_next = STATUS_OK;
    if (cmd == CMD_APPEND) begin
      if (app_ok && carry && seg_full) begin
        status_next = STATUS_FULL;
      end
    end else if (look_ok) begin
      low_next  = prev;
      high_next = rec_zero ? '0 : seg_count;
      if (app_ok) begin
        len_next = rd_cur - prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_low    <= low_next;
      res_high   <= high_next;
      res_len    <= len_next;
      res_status <= status_next;
    end
  end

  assign result.valid       = res_valid;
  assign result.offset_low  = res_low;
  assign result.offset_high = res_high;
  assign result.rec_length  = res_len;
  assign result.status      = res_status;

endmodule

/* src/rot_end_mem.sv */
// End offset memory: one write port and two registered read ports.
module rot_end_mem
  import rot_pkg::*;
(
  input  logic            clk,
  input  mem_wr_t         wr,
  input  mem_rd_t         rd,
  output logic [OffW-1:0] rd_prev,
  output logic [OffW-1:0] rd_cur
);

  logic [OffW-1:0] mem [RECORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_prev <= mem[rd.addr_prev];
      rd_cur  <= mem[rd.addr_cur];
    end
  end

endmodule

/* src/rot_seg_table.sv */
// Boundary crossing table: logs record numbers and counts crossings before a record.
module rot_seg_table
  import rot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  seg_log_t           log_req,
  input  logic [RecNumW-1:0] query,
  output logic               full,
  output logic [HighW-1:0]   count
);

  logic [RecNumW-1:0] seg [MAX_SEGMENTS];
  logic [SegIdxW-1:0] free_idx;
  logic [SegCntW-1:0] cnt;

  // First free slot, if any.
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
      if (seg[i] == '0) begin
        full     = 1'b0;
        free_idx = SegIdxW'(i);
      end
    end
  end

  // Counting stops at the first free slot or the first slot beyond the query.
  always_comb begin
    logic run;
    run = 1'b1;
    cnt = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      run = run && (seg[i] != '0) && (query >= seg[i]);
      if (run) begin
        cnt = cnt + SegCntW'(1);
      end
    end
  end

  assign count = HighW'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        seg[i] <= '0;
      end
    end else if (log_req.en && !full) begin
      seg[free_idx] <= log_req.rec;
    end
  end

endmodule
